// ----- rtl/sahe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahe_pkg
// Shared types and codes for the SPI acknowledge handshake engine.
// ----------------------------------------------------------------------------
package sahe_pkg;

    // item opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_XCHG    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // transaction phases
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_START_SYNC  = 3'd1;
    localparam logic [2:0] PH_MSG         = 3'd2;
    localparam logic [2:0] PH_MID_SYNC    = 3'd3;
    localparam logic [2:0] PH_END_SYNC    = 3'd4;
    localparam logic [2:0] PH_CONFIRM     = 3'd5;
    localparam logic [2:0] PH_END_CONFIRM = 3'd6;
    localparam logic [2:0] PH_FILLER      = 3'd7;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA     = 3'd5;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] message;
        logic       direction;
        logic [7:0] rx_byte;
        logic       select_active;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [7:0] read_data;
        logic       timed_out;
    } t_out_item;

    typedef struct packed {
        logic        role_is_master;
        logic [7:0]  ack_start_code;
        logic [7:0]  ack_end_code;
        logic [7:0]  filler_code;
        logic [15:0] try_limit;
        logic [7:0]  extra_sync_trades;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  phase;
        logic        is_write;
        logic [7:0]  out_message;
        logic [7:0]  expected_byte;
        logic [7:0]  last_received;
        logic [15:0] try_count;
        logic [7:0]  confirm_count;
        logic        timeout;
    } t_state;

endpackage

// ----- rtl/spi_ack_handshake_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_ack_handshake_engine
// Acknowledge handshake sequencer for one byte over a full-duplex SPI link.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one item per SPI
//   event - start (message and direction), exchange finished (received
//   byte, select level) or select released.
//   Output channel (o_out_valid / i_out_stall / o_out_item): exactly one
//   result item per input item - the next byte to load (tx_valid, tx_byte)
//   or, when the transaction ends, done_res with read_data and timed_out.
//   The phase update and the result are computed in the accept cycle and
//   land in the result register. Throughput is one item per cycle while
//   the receiver does not stall; the single result register is refilled
//   in the same cycle it is drained.
//   Stall: input stalls only while a result is held and the receiver
//   stalls; the held result and the state do not move meanwhile.
//   Reset (i_rst_n low, synchronous): phase idle, counters cleared, config
//   registers to defaults (master, codes 0, try limit 16, 4 extra trades),
//   output empty.
//   Config writes (i_cfg_we / i_cfg_idx / i_cfg_data) take effect at the
//   next edge and are meant to happen while no transaction is in flight.
// ----------------------------------------------------------------------------
module spi_ack_handshake_engine import sahe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_result;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic      w_in_acc;

    // input waits only when the result register is full and held
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    sahe_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role_is_master    <= 1'b1;
            r_cfg.ack_start_code    <= 8'd0;
            r_cfg.ack_end_code      <= 8'd0;
            r_cfg.filler_code       <= 8'd0;
            r_cfg.try_limit         <= 16'd16;
            r_cfg.extra_sync_trades <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROLE:      r_cfg.role_is_master    <= i_cfg_data[0];
                CFG_ACK_START: r_cfg.ack_start_code    <= i_cfg_data[7:0];
                CFG_ACK_END:   r_cfg.ack_end_code      <= i_cfg_data[7:0];
                CFG_FILLER:    r_cfg.filler_code       <= i_cfg_data[7:0];
                CFG_TRY_LIMIT: r_cfg.try_limit         <= i_cfg_data[15:0];
                CFG_EXTRA:     r_cfg.extra_sync_trades <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // transaction state advances once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_item <= n_result;
        end
    end

    // a finished transaction always returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_result.done_res) |=> (r_state.phase == PH_IDLE))
        else $error("phase not idle after done");

    // a start always leaves idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.opcode == OP_START) |=> (r_state.phase != PH_IDLE))
        else $error("start did not open a transaction");

    // done and pending byte are exclusive
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> !o_out_item.tx_valid)
        else $error("tx_valid on done result");

    // timeout only reported on done
    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.timed_out) |-> o_out_item.done_res)
        else $error("timeout without done");

    // state holds while the input is stalled
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_state))
        else $error("state moved while stalled");

endmodule

// ----- rtl/sahe_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahe_step
// Next-state and result logic for one item of the handshake engine.
// ----------------------------------------------------------------------------
module sahe_step import sahe_pkg::*; (
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    t_state     n_st;
    logic       w_master;
    logic       w_slave_end;
    logic       w_done;
    logic       w_ok;
    logic [7:0] w_conf_inc;
    logic [15:0] w_try_inc;
    logic [7:0] w_tx;

    assign w_master   = i_cfg.role_is_master;
    assign w_conf_inc = i_state.confirm_count + 8'd1;
    assign w_try_inc  = i_state.try_count + 16'd1;

    always_comb begin
        w_slave_end = !w_master && (i_state.phase inside {PH_END_SYNC, PH_END_CONFIRM,
                                                          PH_FILLER});
        n_st   = i_state;
        w_done = 1'b0;
        w_ok   = 1'b0;
        case (i_item.opcode)
            OP_START: begin
                n_st.is_write      = i_item.direction;
                n_st.try_count     = '0;
                n_st.confirm_count = '0;
                n_st.timeout       = 1'b0;
                n_st.last_received = '0;
                if (i_item.direction) begin
                    n_st.expected_byte = i_cfg.ack_end_code;
                    n_st.out_message   = w_master ? i_item.message
                                                  : (i_item.message ^ i_cfg.ack_end_code);
                end else begin
                    n_st.expected_byte = w_master ? (i_item.message ^ i_cfg.ack_end_code)
                                                  : 8'd0;
                    n_st.out_message   = i_cfg.ack_end_code;
                end
                n_st.phase = (i_item.direction == w_master) ? PH_START_SYNC : PH_MSG;
            end
            OP_RELEASE: begin
                w_done = w_slave_end;
            end
            OP_XCHG: begin
                if (w_slave_end && !i_item.select_active) begin
                    w_done = 1'b1;
                end else begin
                    case (i_state.phase)
                        PH_START_SYNC: begin
                            if (i_item.rx_byte == i_cfg.ack_start_code) begin
                                n_st.confirm_count = '0;
                                n_st.phase = (i_cfg.extra_sync_trades != 8'd0)
                                             ? PH_CONFIRM : PH_MSG;
                            end
                        end
                        PH_MSG: begin
                            n_st.try_count     = w_try_inc;
                            n_st.last_received = i_item.rx_byte;
                            if (!i_state.is_write && !w_master)
                                w_ok = (i_item.rx_byte != i_cfg.ack_start_code) &&
                                       (i_item.rx_byte != i_cfg.ack_end_code);
                            else
                                w_ok = (i_item.rx_byte == i_state.expected_byte);
                            if (w_ok || (w_try_inc >= i_cfg.try_limit)) begin
                                n_st.timeout = !w_ok;
                                n_st.phase = (i_state.is_write == w_master)
                                             ? PH_MID_SYNC : PH_END_SYNC;
                            end
                        end
                        PH_MID_SYNC: begin
                            if (i_item.rx_byte == (w_master ? i_cfg.ack_end_code
                                                            : i_cfg.ack_start_code)) begin
                                n_st.confirm_count = '0;
                                if (i_cfg.extra_sync_trades != 8'd0) n_st.phase = PH_CONFIRM;
                                else w_done = 1'b1;
                            end
                        end
                        PH_CONFIRM: begin
                            n_st.confirm_count = w_conf_inc;
                            if (w_conf_inc >= i_cfg.extra_sync_trades) begin
                                if (i_state.try_count == 16'd0) n_st.phase = PH_MSG;
                                else w_done = 1'b1;
                            end
                        end
                        PH_END_SYNC: begin
                            if (i_item.rx_byte == i_cfg.ack_end_code) begin
                                n_st.confirm_count = '0;
                                if (i_cfg.extra_sync_trades != 8'd0) begin
                                    n_st.phase = PH_END_CONFIRM;
                                end else if (i_state.is_write && !w_master) begin
                                    n_st.phase = PH_FILLER;
                                end else begin
                                    w_done = 1'b1;
                                end
                            end
                        end
                        PH_END_CONFIRM: begin
                            n_st.confirm_count = w_conf_inc;
                            if (w_conf_inc >= i_cfg.extra_sync_trades) begin
                                if (i_state.is_write && !w_master) n_st.phase = PH_FILLER;
                                else w_done = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        if (w_done) n_st.phase = PH_IDLE;
    end

    // byte to load for the next exchange, from the updated phase
    always_comb begin
        case (n_st.phase)
            PH_START_SYNC:  w_tx = i_cfg.ack_start_code;
            PH_MSG:         w_tx = n_st.out_message;
            PH_MID_SYNC:    w_tx = w_master ? i_cfg.ack_start_code : i_cfg.ack_end_code;
            PH_CONFIRM:     w_tx = (n_st.try_count == 16'd0 || w_master)
                                   ? i_cfg.ack_start_code : i_cfg.ack_end_code;
            PH_END_SYNC:    w_tx = i_cfg.ack_end_code;
            PH_END_CONFIRM: w_tx = i_cfg.ack_end_code;
            PH_FILLER:      w_tx = i_cfg.filler_code;
            default:        w_tx = 8'd0;
        endcase
    end

    always_comb begin
        o_state = n_st;
        if (w_done) begin
            o_result.tx_valid  = 1'b0;
            o_result.tx_byte   = 8'd0;
            o_result.done_res  = 1'b1;
            o_result.read_data = n_st.is_write ? 8'd0 : n_st.last_received;
            o_result.timed_out = n_st.timeout;
        end else begin
            o_result.tx_valid  = (n_st.phase != PH_IDLE);
            o_result.tx_byte   = w_tx;
            o_result.done_res  = 1'b0;
            o_result.read_data = 8'd0;
            o_result.timed_out = 1'b0;
        end
    end

endmodule

// ----- bench/spi_ack_handshake_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_ack_handshake_engine_tb
// Self-checking bench for the SPI acknowledge handshake engine. A behavioral
// predictor tracks phase, counters and registers and works out the reply to
// every accepted item. The reply monitor compares each result field by field
// against the oldest expected reply. Directed transactions cover the four
// role/direction paths, timeouts and ignored items. Register-swept random
// transactions follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module spi_ack_handshake_engine_tb;
    import sahe_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    spi_ack_handshake_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Register copies, starting at their reset values.
    logic        cf_master = 1'b1;
    logic [7:0]  cf_start  = 8'h00;
    logic [7:0]  cf_end    = 8'h00;
    logic [7:0]  cf_fill   = 8'h00;
    logic [15:0] cf_limit  = 16'd16;
    logic [7:0]  cf_extra  = 8'd4;

    // Predicted transaction state.
    logic [2:0]  hs_phase    = PH_IDLE;
    logic        hs_write    = 1'b0;
    logic [7:0]  hs_tx_msg   = 8'h00;  // byte sent during message trades
    logic [7:0]  hs_want     = 8'h00;  // byte the peer must return
    logic [7:0]  hs_last_rx  = 8'h00;
    logic [15:0] hs_trades   = 16'd0;
    logic [7:0]  hs_confirms = 8'd0;
    logic        hs_timeout  = 1'b0;

    t_out_item   pending_replies[$];
    int unsigned mismatches = 0;
    int unsigned live_items = 0;   // starts, exchanges while busy, releases that finish
    logic        no_idle = 1'b0;   // when set neither side idles or stalls

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Slave in a phase that a released select can end.
    function automatic logic in_slave_tail();
        return !cf_master && (hs_phase == PH_END_SYNC ||
                              hs_phase == PH_END_CONFIRM || hs_phase == PH_FILLER);
    endfunction

    // Byte to load for the next exchange in the current phase.
    function automatic logic [7:0] next_tx_byte();
        case (hs_phase)
            PH_START_SYNC:                return cf_start;
            PH_MSG:                       return hs_tx_msg;
            PH_MID_SYNC:                  return cf_master ? cf_start : cf_end;
            // confirms after the start sync always echo the start code
            PH_CONFIRM:                   return (hs_trades == 16'd0 || cf_master) ?
                                                 cf_start : cf_end;
            PH_END_SYNC, PH_END_CONFIRM:  return cf_end;
            PH_FILLER:                    return cf_fill;
            default:                      return 8'h00;
        endcase
    endfunction

    // Slave write goes on to filler; everything else finishes here.
    function automatic logic leave_end_sync();
        if (hs_write && !cf_master) begin
            hs_phase = PH_FILLER;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_out_item handshake_predict(t_in_item it);
        t_out_item r;
        logic      fin;
        logic      hit;
        logic      tail;
        r    = '0;
        fin  = 1'b0;
        tail = in_slave_tail();
        case (it.opcode)
            OP_START: begin
                // a start while busy simply abandons the old transaction
                hs_write    = it.direction;
                hs_trades   = 16'd0;
                hs_confirms = 8'd0;
                hs_timeout  = 1'b0;
                hs_last_rx  = 8'h00;
                if (hs_write) begin
                    hs_want   = cf_end;
                    hs_tx_msg = cf_master ? it.message : it.message ^ cf_end;
                end else begin
                    hs_want   = cf_master ? it.message ^ cf_end : 8'h00;
                    hs_tx_msg = cf_end;
                end
                hs_phase = (hs_write == cf_master) ? PH_START_SYNC : PH_MSG;
            end
            OP_RELEASE: fin = tail;
            OP_XCHG: begin
                if (tail && !it.select_active) begin
                    fin = 1'b1;
                end else begin
                    case (hs_phase)
                        PH_START_SYNC: begin
                            if (it.rx_byte == cf_start) begin
                                hs_confirms = 8'd0;
                                hs_phase = (cf_extra != 8'd0) ? PH_CONFIRM : PH_MSG;
                            end
                        end
                        PH_MSG: begin
                            hs_trades  = hs_trades + 16'd1;
                            hs_last_rx = it.rx_byte;
                            // slave read takes any byte that is not a code
                            if (!hs_write && !cf_master)
                                hit = (it.rx_byte != cf_start) && (it.rx_byte != cf_end);
                            else
                                hit = (it.rx_byte == hs_want);
                            // a zero try limit still allows one trade
                            if (hit || hs_trades >= cf_limit) begin
                                hs_timeout = !hit;
                                hs_phase = (hs_write == cf_master) ? PH_MID_SYNC : PH_END_SYNC;
                            end
                        end
                        PH_MID_SYNC: begin
                            if (it.rx_byte == (cf_master ? cf_end : cf_start)) begin
                                hs_confirms = 8'd0;
                                if (cf_extra != 8'd0) hs_phase = PH_CONFIRM;
                                else fin = 1'b1;
                            end
                        end
                        PH_CONFIRM: begin
                            hs_confirms = hs_confirms + 8'd1;
                            if (hs_confirms >= cf_extra) begin
                                if (hs_trades == 16'd0) hs_phase = PH_MSG;
                                else fin = 1'b1;
                            end
                        end
                        PH_END_SYNC: begin
                            if (it.rx_byte == cf_end) begin
                                hs_confirms = 8'd0;
                                if (cf_extra != 8'd0) hs_phase = PH_END_CONFIRM;
                                else fin = leave_end_sync();
                            end
                        end
                        PH_END_CONFIRM: begin
                            hs_confirms = hs_confirms + 8'd1;
                            if (hs_confirms >= cf_extra) fin = leave_end_sync();
                        end
                        default: ;
                    endcase
                end
            end
            default: ;  // unused opcode: nothing changes
        endcase
        if (fin) begin
            hs_phase    = PH_IDLE;
            r.done_res  = 1'b1;
            r.read_data = hs_write ? 8'h00 : hs_last_rx;
            r.timed_out = hs_timeout;
        end else begin
            r.tx_valid = (hs_phase != PH_IDLE);
            r.tx_byte  = next_tx_byte();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Sends one item after a random gap and predicts its reply on acceptance.
    // Valid stays high afterwards so back-to-back items need no toggle.
    task automatic send_item(t_in_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.opcode == OP_START || (it.opcode == OP_XCHG && hs_phase != PH_IDLE) ||
            (it.opcode == OP_RELEASE && in_slave_tail()))
            live_items++;
        pending_replies.push_back(handshake_predict(it));
    endtask

    // Holds off the sender until every expected reply has been taken.
    // Lowers valid and waits on the clock before the first check, so valid
    // is never lowered and raised in the same step.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // Register write, only once every expected reply has been taken.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ROLE:      cf_master = val[0];
            CFG_ACK_START: cf_start  = val[7:0];
            CFG_ACK_END:   cf_end    = val[7:0];
            CFG_FILLER:    cf_fill   = val[7:0];
            CFG_TRY_LIMIT: cf_limit  = val;
            CFG_EXTRA:     cf_extra  = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] biased_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic start_txn(logic [7:0] msg, logic dir);
        t_in_item it;
        it           = t_in_item'($urandom);
        it.opcode    = OP_START;
        it.message   = msg;
        it.direction = dir;
        send_item(it);
    endtask

    task automatic exchange(logic [7:0] rx, logic sel);
        t_in_item it;
        it               = t_in_item'($urandom);
        it.opcode        = OP_XCHG;
        it.rx_byte       = rx;
        it.select_active = sel;
        send_item(it);
    endtask

    // Exchange that mostly returns what the current phase waits for.
    function automatic t_in_item make_exchange();
        t_in_item it;
        it        = t_in_item'($urandom);
        it.opcode = OP_XCHG;
        if ($urandom_range(0, 9) < 7) begin
            case (hs_phase)
                PH_START_SYNC: it.rx_byte = cf_start;
                PH_MID_SYNC:   it.rx_byte = cf_master ? cf_end : cf_start;
                PH_END_SYNC:   it.rx_byte = cf_end;
                PH_MSG: begin
                    if (!hs_write && !cf_master) begin
                        while (it.rx_byte == cf_start || it.rx_byte == cf_end)
                            it.rx_byte = 8'($urandom);
                    end else begin
                        it.rx_byte = hs_want;
                    end
                end
                default: ;
            endcase
        end
        // keep select asserted in the slave tail most of the time
        if (in_slave_tail()) it.select_active = ($urandom_range(0, 7) != 0);
        return it;
    endfunction

    // One transaction with random content; noise, releases and a rare role
    // flip mid-transaction are mixed in. Stops when done or after cap steps.
    task automatic run_txn(int unsigned cap);
        t_in_item    it;
        int unsigned steps;
        int unsigned pick;
        steps = 0;
        it    = t_in_item'($urandom);
        it.opcode    = OP_START;
        it.message   = biased_byte();
        send_item(it);
        while (hs_phase != PH_IDLE && steps < cap) begin
            pick = $urandom_range(0, 63);
            if (pick == 0) begin
                set_reg(CFG_ROLE, 16'(!cf_master));
            end else begin
                if (pick < 3) begin
                    // any opcode, a start abandons the transaction
                    it = t_in_item'($urandom);
                end else if (pick < 8 && in_slave_tail()) begin
                    it = t_in_item'($urandom);
                    it.opcode = OP_RELEASE;
                end else begin
                    it = make_exchange();
                end
                send_item(it);
            end
            steps++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Unused opcode, exchange and release while idle, then a default-register
    // master write.
    task automatic test_ignored_items();
        t_in_item it;
        it = '1;
        send_item(it);
        exchange(8'hFF, 1'b1);
        it = '0;
        it.opcode = OP_RELEASE;
        send_item(it);
        start_txn(8'h00, 1'b1);
        exchange(8'h00, 1'b0);
    endtask

    task automatic test_master_paths();
        set_reg(CFG_ROLE, 16'd1);
        set_reg(CFG_ACK_START, 16'h00A5);
        set_reg(CFG_ACK_END, 16'h005A);
        set_reg(CFG_FILLER, 16'h00FF);
        set_reg(CFG_TRY_LIMIT, 16'd1);
        set_reg(CFG_EXTRA, 16'd0);
        // write: bad acknowledge with a try limit of one times out
        start_txn(8'hFF, 1'b1);
        exchange(8'hA5, 1'b1);
        exchange(8'h00, 1'b1);
        exchange(8'h5A, 1'b1);
        // read: message XOR end code accepted first time
        start_txn(8'h00, 1'b0);
        exchange(8'h5A, 1'b0);
        exchange(8'h5A, 1'b0);
        // zero try limit behaves as one trade
        set_reg(CFG_TRY_LIMIT, 16'd0);
        start_txn(8'h3C, 1'b0);
        exchange(8'hFF, 1'b1);
        exchange(8'h5A, 1'b1);
        // start while busy abandons the write
        start_txn(8'h81, 1'b1);
        start_txn(8'h7E, 1'b0);
    endtask

    task automatic test_slave_paths();
        // role switches to slave while the master read is still open
        set_reg(CFG_ROLE, 16'd0);
        set_reg(CFG_EXTRA, 16'd1);
        set_reg(CFG_TRY_LIMIT, 16'hFFFF);
        exchange(8'h00, 1'b1);
        exchange(8'hA5, 1'b1);
        exchange(8'h42, 1'b1);
        // slave write through filler, ended by a select release
        start_txn(8'h80, 1'b1);
        exchange(8'h5A, 1'b1);
        exchange(8'h5A, 1'b1);
        exchange(8'h00, 1'b1);
        exchange(8'h33, 1'b1);
        exchange(8'h44, 1'b0);
        // slave read: start sync, confirm, end code rejected in the message trade
        start_txn(8'h11, 1'b0);
        exchange(8'hA5, 1'b1);
        exchange(8'h00, 1'b1);
        exchange(8'h5A, 1'b1);
        exchange(8'hFF, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned round;
        logic [15:0] lim;
        round = 0;
        while (live_items < 1150) begin
            no_idle = ($urandom_range(0, 3) == 0);
            set_reg(CFG_ROLE, 16'($urandom_range(0, 1)));
            set_reg(CFG_ACK_START, 16'(biased_byte()));
            // equal start and end codes now and then
            if ($urandom_range(0, 7) == 0) set_reg(CFG_ACK_END, 16'(cf_start));
            else set_reg(CFG_ACK_END, 16'(biased_byte()));
            set_reg(CFG_FILLER, 16'(biased_byte()));
            case ($urandom_range(0, 7))
                0:       lim = 16'd0;
                1:       lim = 16'd1;
                2:       lim = 16'hFFFF;
                default: lim = 16'($urandom_range(2, 6));
            endcase
            set_reg(CFG_TRY_LIMIT, lim);
            // the longest confirm run only in one short round
            if (round == 1) set_reg(CFG_EXTRA, 16'd255);
            else set_reg(CFG_EXTRA, 16'($urandom_range(0, 3)));
            repeat ((round == 1) ? 2 : 6) run_txn(600);
            round++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall and reply check
    // ------------------------------------------------------------------------

    task automatic field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s expected %h got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    initial begin : reply_monitor
        int unsigned hold;
        t_out_item   exp_r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t ns: reply with none expected, got %h", $time, o_out_item);
                    mismatches++;
                end else begin
                    exp_r = pending_replies.pop_front();
                    field_check("tx_valid", 8'(exp_r.tx_valid), 8'(o_out_item.tx_valid));
                    field_check("tx_byte", exp_r.tx_byte, o_out_item.tx_byte);
                    field_check("done_res", 8'(exp_r.done_res), 8'(o_out_item.done_res));
                    field_check("read_data", exp_r.read_data, o_out_item.read_data);
                    field_check("timed_out", 8'(exp_r.timed_out),
                                8'(o_out_item.timed_out));
                end
                hold = no_idle ? 0 : $urandom_range(0, 16);
            end
            i_out_stall <= (hold != 0);
            if (hold != 0) hold--;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_items();
        test_master_paths();
        test_slave_paths();
        test_random_traffic();
        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- spi_ack_handshake_engine.f -----
rtl/sahe_pkg.sv
rtl/sahe_step.sv
rtl/spi_ack_handshake_engine.sv
bench/spi_ack_handshake_engine_tb.sv
